>>> hdl/checksum_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer engine RTL.
`ifndef CHECKSUM_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define CHECKSUM_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define CFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define CFD_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> hdl/cfd_pkg.sv
// Types and constants of the checksum frame deframer.
`timescale 1ns / 1ps
package cfd_pkg;
   localparam int BufDepth = 256;
   localparam int AddrW    = $clog2(BufDepth);
   localparam int FillW    = AddrW + 1;

   localparam logic [7:0] MinFrame = 8'd4;

   // Operation codes.
   localparam logic OpPush = 1'b0;
   localparam logic OpRead = 1'b1;

   // Result status codes.
   localparam logic [1:0] StatParsing = 2'd0;
   localparam logic [1:0] StatFrame   = 2'd1;
   localparam logic [1:0] StatRead    = 2'd2;

   // Register indexes on the CSR port.
   localparam logic [1:0] RegHeaderFirst  = 2'd0;
   localparam logic [1:0] RegHeaderSecond = 2'd1;
   localparam logic [1:0] RegMinLength    = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic [7:0] read_index;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] payload_length;
      logic [7:0] read_data;
      logic [7:0] dropped_count;
   } res_type;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] length_limit;
   } cfg_type;
endpackage

>>> hdl/cfd_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic [7:0] read_index;
   modport source (output valid, operation, data_byte, read_index, input ready);
   modport sink (input valid, operation, data_byte, read_index, output ready);
endinterface

interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] payload_length;
   logic [7:0] read_data;
   logic [7:0] dropped_count;
   modport source (output valid, status, payload_length, read_data, dropped_count,
                   input ready);
   modport sink (input valid, status, payload_length, read_data, dropped_count,
                 output ready);
endinterface

>>> hdl/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/cfd_front.sv
// Request intake: accepts transfers into a two-entry command queue.
`timescale 1ns / 1ps
module cfd_front import cfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   cfd_req_if.sink req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign pop       = cmd_take && cmd_valid;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // Queue pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the operation bit is sampled as the command class.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{operation:  (req.operation == OpRead) ? OpRead : OpPush,
                                 data_byte:  req.data_byte,
                                 read_index: req.read_index};
      end
   end
endmodule

>>> hdl/cfd_engine.sv
// Frame engine: stores bytes, rescans the buffer head and answers reads.
`timescale 1ns / 1ps
`include "checksum_frame_deframer_unit_assert.svh"
module cfd_engine import cfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_take,
   cfd_rsp_if.source rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_RD0, S_H0, S_H1, S_LEN, S_SUM, S_RDQ, S_RDA, S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [AddrW-1:0] head_ff, head_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             ready_ff, ready_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       idx_ff, idx_in;
   logic [7:0]       drop_ff, drop_in;
   cmd_type          cmd_ff, cmd_in;
   res_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [AddrW-1:0] ram_waddr, ram_raddr;
   logic [7:0]       ram_rdata;
   logic [7:0]       drop_next;
   logic [FillW-1:0] fill_dec;
   logic [7:0]       held_plen;

   cfd_ram #(.WIDTH(8), .DEPTH(BufDepth)) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_ff.data_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign drop_next = (drop_ff == 8'hFF) ? drop_ff : drop_ff + 8'd1;
   assign fill_dec  = fill_ff - FillW'(1);
   assign held_plen = ready_ff ? len_ff - MinFrame : 8'd0;
   assign ram_waddr = head_ff + fill_ff[AddrW-1:0];

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      ready_in     = ready_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      drop_in      = drop_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_take     = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               drop_in  = 8'd0;
               if (cmd.operation == OpRead) begin
                  res_in = '{status: StatRead, payload_length: held_plen,
                             read_data: 8'd0, dropped_count: 8'd0};
                  if (ready_ff && (cmd.read_index < held_plen)) begin
                     state_in = S_RDQ;
                  end else begin
                     state_in = S_EMIT;
                  end
               end else begin
                  if (ready_ff) begin
                     head_in  = '0;
                     fill_in  = '0;
                     ready_in = 1'b0;
                  end
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            fill_in  = fill_ff + FillW'(1);
            state_in = S_RD0;
         end
         S_RD0: begin
            ram_raddr = head_ff;
            state_in  = S_H0;
         end
         S_H0, S_H1, S_LEN, S_SUM: begin
            // A mismatch drops the head byte; a short prefix ends the push.
            logic bad, wait_more;
            bad       = 1'b0;
            wait_more = 1'b0;
            case (state_ff)
               S_H0: begin
                  if (ram_rdata != cfg.header_first) bad = 1'b1;
                  else if (fill_ff < FillW'(2)) wait_more = 1'b1;
                  else begin
                     ram_raddr = head_ff + AddrW'(1);
                     state_in  = S_H1;
                  end
               end
               S_H1: begin
                  if (ram_rdata != cfg.header_second) bad = 1'b1;
                  else if (fill_ff < FillW'(3)) wait_more = 1'b1;
                  else begin
                     ram_raddr = head_ff + AddrW'(2);
                     state_in  = S_LEN;
                  end
               end
               S_LEN: begin
                  len_in = ram_rdata;
                  if (ram_rdata < cfg.length_limit) bad = 1'b1;
                  else if (fill_ff < {1'b0, ram_rdata}) wait_more = 1'b1;
                  else begin
                     ram_raddr = head_ff;
                     sum_in    = 8'd0;
                     idx_in    = 8'd0;
                     state_in  = S_SUM;
                  end
               end
               default: begin
                  if (idx_ff == len_ff - 8'd1) begin
                     if (ram_rdata == sum_ff) begin
                        ready_in = 1'b1;
                        res_in   = '{status: StatFrame, payload_length: len_ff - MinFrame,
                                     read_data: 8'd0, dropped_count: drop_ff};
                        state_in = S_EMIT;
                     end else begin
                        bad = 1'b1;
                     end
                  end else begin
                     sum_in    = sum_ff + ram_rdata;
                     idx_in    = idx_ff + 8'd1;
                     ram_raddr = head_ff + idx_ff[AddrW-1:0] + AddrW'(1);
                  end
               end
            endcase
            if (bad) begin
               head_in = head_ff + AddrW'(1);
               fill_in = fill_dec;
               drop_in = drop_next;
               if (fill_dec == '0) begin
                  res_in   = '{status: StatParsing, payload_length: 8'd0,
                               read_data: 8'd0, dropped_count: drop_next};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_RD0;
               end
            end else if (wait_more) begin
               res_in   = '{status: StatParsing, payload_length: 8'd0,
                            read_data: 8'd0, dropped_count: drop_ff};
               state_in = S_EMIT;
            end
         end
         S_RDQ: begin
            ram_raddr = head_ff + AddrW'(3) + cmd_ff.read_index[AddrW-1:0];
            state_in  = S_RDA;
         end
         S_RDA: begin
            res_in.read_data = ram_rdata;
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      drop_ff     <= drop_in;
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_data_ff.status;
   assign rsp.payload_length = rsp_data_ff.payload_length;
   assign rsp.read_data      = rsp_data_ff.read_data;
   assign rsp.dropped_count  = rsp_data_ff.dropped_count;

   `CFD_ASSERT(a_frame_len, clock, reset, !ready_ff || (len_ff >= MinFrame), "held frame shorter than four bytes")
   `CFD_ASSERT(a_fill_bound, clock, reset, fill_ff <= FillW'(BufDepth), "buffer fill beyond its depth")
   `CFD_ASSERT_NEXT(a_take_cmd, clock, reset, (state_ff == S_IDLE) && cmd_valid, state_ff != S_IDLE, "queued command not taken")
endmodule

>>> hdl/checksum_frame_deframer_unit.sv
// Top level of the checksum frame deframer.
//
// Requests arrive on req_chan: a push stores one received byte and rescans the
// buffer head for a frame, a read returns one payload byte of the held frame.
// Every request gives exactly one response transfer on rsp_chan, in order.
// A read fetches the payload byte from the buffer RAM when its index lies in
// the held frame and skips the fetch otherwise. A push writes its byte and
// then rescans from the buffer head: first header, second header, length and
// checksum. Each dropped head byte restarts the rescan at the new head. The
// engine works on one request at a time. Requests wait in a two-entry queue
// while the engine works, and a finished response waits in the output
// register, so a stalled receiver stops the engine only when a second
// response is ready. The header and minimum length registers sit on the APB
// port at byte addresses 0, 4 and 8; the user must write them only while
// idle, and the block itself does not enforce this.
// Reset empties the buffer, drops any held frame and clears both channels;
// the buffer RAM itself is not cleared.
`timescale 1ns / 1ps
module checksum_frame_deframer_unit import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfd_req_if.sink     req_chan,
   cfd_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [7:0] hdr_first_ff, hdr_second_ff, min_len_ff;
   logic       csr_write;
   cfg_type    cfg;
   logic       cmd_valid, cmd_take;
   cmd_type    cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= 8'd0;
         hdr_second_ff <= 8'd0;
         min_len_ff    <= MinFrame;
      end else if (csr_write) begin
         case (paddr[3:2])
            RegHeaderFirst:  hdr_first_ff  <= pwdata[7:0];
            RegHeaderSecond: hdr_second_ff <= pwdata[7:0];
            RegMinLength:    min_len_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[3:2])
         RegHeaderFirst:  prdata = {24'd0, hdr_first_ff};
         RegHeaderSecond: prdata = {24'd0, hdr_second_ff};
         RegMinLength:    prdata = {24'd0, min_len_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // A minimum below four still needs both headers, length and checksum.
   assign cfg = '{header_first:  hdr_first_ff,
                  header_second: hdr_second_ff,
                  length_limit:  (min_len_ff < MinFrame) ? MinFrame : min_len_ff};

   cfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   cfd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp       (rsp_chan)
   );
endmodule

>>> tb/checksum_frame_deframer_checker.sv
// Response checker for the checksum frame deframer: tracks state, predicts and compares.
`timescale 1ns / 1ps
module checksum_frame_deframer_checker import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfd_req_if          req,
   cfd_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);
   typedef enum int {SCAN_WAIT, SCAN_BAD, SCAN_DONE} scan_type;

   // Shadow copy of the configuration and the receive buffer.
   logic [7:0] hdr_one, hdr_two, len_floor;
   logic [7:0] rx_bytes [BufDepth];
   logic [7:0] head;
   logic [8:0] fill;
   logic       held;
   res_type    expected_q [$];

   function automatic logic [7:0] peek(int offset);
      return rx_bytes[8'(int'(head) + offset)];
   endfunction

   // Classifies what sits at the buffer head.
   function automatic scan_type scan_head();
      int lim;
      int flen;
      logic [7:0] sum;
      lim = (len_floor < MinFrame) ? 4 : int'(len_floor);
      sum = 8'd0;
      if (fill < 1) return SCAN_WAIT;
      if (peek(0) != hdr_one) return SCAN_BAD;
      if (fill < 2) return SCAN_WAIT;
      if (peek(1) != hdr_two) return SCAN_BAD;
      if (fill < 3) return SCAN_WAIT;
      flen = int'(peek(2));
      if (flen < lim) return SCAN_BAD;
      if (int'(fill) < flen) return SCAN_WAIT;
      for (int i = 0; i + 1 < flen; i++) sum = sum + peek(i);
      if (peek(flen - 1) != sum) return SCAN_BAD;
      return SCAN_DONE;
   endfunction

   // Applies one request to the shadow state and returns the response it causes.
   function automatic res_type deframe_step(cmd_type c);
      res_type r;
      scan_type s;
      r = '0;
      if (c.operation == OpRead) begin
         r.status = StatRead;
         if (held) begin
            r.payload_length = peek(2) - 8'd4;
            if (c.read_index < r.payload_length) r.read_data = peek(3 + int'(c.read_index));
         end
      end else begin
         r.status = StatParsing;
         if (held) begin
            fill = 0;
            head = 0;
            held = 1'b0;
         end
         if (fill >= BufDepth) begin
            head = head + 8'd1;
            fill = fill - 9'd1;
         end
         rx_bytes[8'(int'(head) + int'(fill))] = c.data_byte;
         fill = fill + 9'd1;
         while (fill > 0) begin
            s = scan_head();
            if (s == SCAN_WAIT) break;
            if (s == SCAN_DONE) begin
               held = 1'b1;
               r.status = StatFrame;
               r.payload_length = peek(2) - 8'd4;
               break;
            end
            head = head + 8'd1;
            fill = fill - 9'd1;
            if (r.dropped_count != 8'd255) r.dropped_count = r.dropped_count + 8'd1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      res_type want;
      cmd_type c;
      if (reset) begin
         hdr_one <= 8'd0;
         hdr_two <= 8'd0;
         len_floor <= MinFrame;
         head = 0;
         fill = 0;
         held = 1'b0;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         // Register writes on the configuration port.
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               RegHeaderFirst:  hdr_one <= pwdata[7:0];
               RegHeaderSecond: hdr_two <= pwdata[7:0];
               RegMinLength:    len_floor <= pwdata[7:0];
               default: ;
            endcase
         end
         // Each accepted request queues the response it should produce.
         if (req.valid && req.ready) begin
            c.operation = req.operation;
            c.data_byte = req.data_byte;
            c.read_index = req.read_index;
            expected_q.insert(expected_q.size(), deframe_step(c));
         end
         // Each response transfer is matched against the oldest expectation.
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response status=%0d len=%0d data=%0d drop=%0d",
                        $time, rsp.status, rsp.payload_length, rsp.read_data,
                        rsp.dropped_count);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp.status !== want.status || rsp.payload_length !== want.payload_length ||
                   rsp.read_data !== want.read_data ||
                   rsp.dropped_count !== want.dropped_count) begin
                  $display("%0t: mismatch expected status=%0d len=%0d data=%0d drop=%0d",
                           $time, want.status, want.payload_length, want.read_data,
                           want.dropped_count);
                  $display("%0t:          actual   status=%0d len=%0d data=%0d drop=%0d",
                           $time, rsp.status, rsp.payload_length, rsp.read_data,
                           rsp.dropped_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_q.size();
      end
   end
endmodule

>>> tb/checksum_frame_deframer_unit_tb.sv
// Testbench top for the checksum frame deframer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module checksum_frame_deframer_unit_tb import cfd_pkg::*;;
   localparam int CycleLimit = 3000000;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending;
   int          cycles;
   int          tx_idle, rx_idle;
   int          item_count;
   logic        pressure_go, pressure_done;
   logic [7:0]  cur_hdr_one, cur_hdr_two, cur_floor;

   cfd_req_if req_chan ();
   cfd_rsp_if rsp_chan ();

   checksum_frame_deframer_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   checksum_frame_deframer_checker u_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off to fill the block.
   initial begin
      rsp_chan.ready = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_go && !pressure_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            pressure_done = 1'b1;
         end
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // Offers one request and waits for its transfer.
   task automatic send_item(logic op, logic [7:0] data, logic [7:0] idx);
      if ($urandom_range(99) < tx_idle) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.data_byte <= data;
      req_chan.read_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      item_count++;
   endtask

   task automatic push_byte(logic [7:0] b);
      send_item(OpPush, b, 8'($urandom));
   endtask

   task automatic read_byte(logic [7:0] idx);
      send_item(OpRead, 8'($urandom), idx);
   endtask

   // Sends one frame of the given total length; corrupt spoils the checksum.
   task automatic send_frame(int flen, bit corrupt);
      logic [7:0] sum;
      logic [7:0] b;
      sum = 8'd0;
      for (int i = 0; i + 1 < flen; i++) begin
         if (i == 0) b = cur_hdr_one;
         else if (i == 1) b = cur_hdr_two;
         else if (i == 2) b = 8'(flen);
         else b = 8'($urandom);
         sum = sum + b;
         push_byte(b);
      end
      if (corrupt) sum = sum + 8'($urandom_range(1, 255));
      push_byte(sum);
   endtask

   // Configuration writes happen only once every response is back.
   task automatic write_reg(logic [1:0] index, logic [7:0] value);
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(logic [7:0] h1, logic [7:0] h2, logic [7:0] floor_len);
      write_reg(RegHeaderFirst, h1);
      write_reg(RegHeaderSecond, h2);
      write_reg(RegMinLength, floor_len);
      cur_hdr_one = h1;
      cur_hdr_two = h2;
      cur_floor = floor_len;
   endtask

   // Random traffic: mostly framed sequences, with noise, broken frames and reads.
   task automatic random_traffic(int target);
      int lo, flen, pick;
      lo = (cur_floor < 4) ? 4 : int'(cur_floor);
      while (item_count < target) begin
         if (item_count > 250 && item_count < 500) begin
            tx_idle = 78;
            rx_idle = 21;
         end else if (item_count >= 500) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         pick = $urandom_range(99);
         if (lo > 200) flen = 255;
         else if ($urandom_range(19) == 0) flen = $urandom_range(lo, 60 > lo ? 60 : lo);
         else flen = lo + $urandom_range(0, 8);
         if (pick < 70) begin
            send_frame(flen, 1'b0);
            repeat ($urandom_range(0, 3)) read_byte($urandom_range(0, 3) == 0 ?
                                              8'($urandom) : 8'($urandom_range(0, flen - 3)));
         end else if (pick < 80) begin
            send_frame(flen, 1'b1);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) push_byte($urandom_range(1) ? 8'($urandom) : cur_hdr_one);
         end else begin
            read_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OpPush;
      req_chan.data_byte = 8'd0;
      req_chan.read_index = 8'd0;
      item_count = 0;
      tx_idle = 21;
      rx_idle = 78;
      pressure_go = 1'b0;
      cur_hdr_one = 8'd0;
      cur_hdr_two = 8'd0;
      cur_floor = MinFrame;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset headers, read with no frame, empty frame, reads out of range.
      read_byte(8'd0);
      send_frame(4, 1'b0);
      read_byte(8'd0);
      read_byte(8'd255);
      // Push after a frame, wrong first and second header, short length.
      push_byte(8'hFF);
      push_byte(8'd0);
      push_byte(8'h7E);
      push_byte(8'd0);
      push_byte(8'd0);
      push_byte(8'd3);
      // Bad checksum, then a good frame with payload read at both ends and past it.
      send_frame(6, 1'b1);
      send_frame(7, 1'b0);
      read_byte(8'd0);
      read_byte(8'd2);
      read_byte(8'd3);

      // Minimum below four, alternating headers.
      configure(8'hA5, 8'h5A, 8'd0);
      send_frame(4, 1'b0);
      read_byte(8'd1);
      random_traffic(130);

      // Pressure: a long receiver hold-off while requests keep coming.
      configure(8'h00, 8'hFF, 8'd4);
      pressure_go <= 1'b1;
      random_traffic(260);

      // Largest minimum: only full-length frames pass.
      configure(8'hFF, 8'hFF, 8'd255);
      send_frame(255, 1'b0);
      read_byte(8'd250);
      read_byte(8'd251);
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(8'd254);
      random_traffic(item_count + 20);

      // Random settings for the remainder.
      for (int p = 0; p < 4; p++) begin
         configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 16)));
         random_traffic(520 + 70 * p);
      end
      configure(8'h55, 8'hAA, 8'd4);
      random_traffic(750);

      req_chan.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+hdl
hdl/cfd_pkg.sv
hdl/cfd_ifs.sv
hdl/cfd_ram.sv
hdl/cfd_front.sv
hdl/cfd_engine.sv
hdl/checksum_frame_deframer_unit.sv
tb/checksum_frame_deframer_checker.sv
tb/checksum_frame_deframer_unit_tb.sv
